@@ rtl/miller_rabin_witness_test_core_defines.svh @@
// ----------------------------------------------------------------------------
// miller rabin witness test core: assertion macros
// shared concurrent assertion forms for the rtl
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_WITNESS_TEST_CORE_DEFINES_SVH
`define MILLER_RABIN_WITNESS_TEST_CORE_DEFINES_SVH

// same-cycle implication
`define MRWT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MRWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mrwt_pkg.sv @@
// ----------------------------------------------------------------------------
// mrwt_pkg
// widths shared by the channel interfaces and the witness test rtl
// ----------------------------------------------------------------------------
package mrwt_pkg;

   // payload width of candidate and witness on the channel
   localparam int FIELD_WIDTH = 32;

   // default arithmetic width of the core
   localparam int NUM_WIDTH_DEFAULT = 32;

endpackage

@@ rtl/mrwt_channels.sv @@
// ----------------------------------------------------------------------------
// mrwt channel interfaces
// valid/ready channels for the request and the response
// ----------------------------------------------------------------------------
interface mrwt_req_if;
   logic                              valid;
   logic                              ready;
   logic [mrwt_pkg::FIELD_WIDTH-1:0]  candidate;
   logic [mrwt_pkg::FIELD_WIDTH-1:0]  witness;

   modport source (output valid, output candidate, output witness, input ready);
   modport sink   (input valid, input candidate, input witness, output ready);
endinterface

interface mrwt_rsp_if;
   logic valid;
   logic ready;
   logic probable_prime;

   modport source (output valid, output probable_prime, input ready);
   modport sink   (input valid, input probable_prime, output ready);
endinterface

@@ rtl/mrwt_modmul.sv @@
// ----------------------------------------------------------------------------
// mrwt_modmul
// shift-add modular multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module mrwt_modmul #(
   parameter int NUM_WIDTH = mrwt_pkg::NUM_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] op_a,
   input  logic [NUM_WIDTH-1:0] op_b,
   input  logic [NUM_WIDTH-1:0] modulus,
   output logic                 busy,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] product
);
   import mrwt_pkg::*;

   localparam int CW = $clog2(NUM_WIDTH);
   localparam int SW = NUM_WIDTH + 2;

   logic [NUM_WIDTH-1:0] acc_ff, acc_in;
   logic [NUM_WIDTH-1:0] a_ff, a_in;
   logic [NUM_WIDTH-1:0] b_ff, b_in;
   logic [NUM_WIDTH-1:0] m_ff, m_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [SW-1:0] sum;
   logic [SW-1:0] m1;
   logic [SW-1:0] m2;
   logic [SW-1:0] red;

   // op_a < modulus keeps 2*acc + a below 3*modulus
   always_comb begin
      m1  = {2'b00, m_ff};
      m2  = {1'b0, m_ff, 1'b0};
      sum = {1'b0, acc_ff, 1'b0} + (b_ff[NUM_WIDTH-1] ? {2'b00, a_ff} : '0);
      priority if (sum >= m2) begin
         red = sum - m2;
      end else if (sum >= m1) begin
         red = sum - m1;
      end else begin
         red = sum;
      end
   end

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      priority if (start) begin
         acc_in  = '0;
         a_in    = op_a;
         b_in    = op_b;
         m_in    = modulus;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = red[NUM_WIDTH-1:0];
         b_in   = {b_ff[NUM_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NUM_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      cnt_ff <= cnt_in;
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ rtl/miller_rabin_witness_test_core.sv @@
// flow: candidates below 4 or even are settled by the checks in S_LOAD with no
// multiply; otherwise the test runs at most 2 * NUM_WIDTH - 2 modular multiplies,
// one at a time on the one shift-add multiplier
// throughput: one transaction at a time; the next request is taken once the
// result sits in the output register
// reset: synchronous active-high, returns to idle with no response pending
// ----------------------------------------------------------------------------
// miller_rabin_witness_test_core
// single-witness miller-rabin test over a shared modular multiplier
// ----------------------------------------------------------------------------
`include "miller_rabin_witness_test_core_defines.svh"

module miller_rabin_witness_test_core #(
   parameter int NUM_WIDTH = mrwt_pkg::NUM_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   mrwt_req_if.sink    req_chan,
   mrwt_rsp_if.source  rsp_chan
);
   import mrwt_pkg::*;

   localparam int W  = NUM_WIDTH;
   localparam int KW = $clog2(NUM_WIDTH);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_LOAD     = 4'd1;
   localparam logic [3:0] S_DECOMP   = 4'd2;
   localparam logic [3:0] S_RED_WAIT = 4'd3;
   localparam logic [3:0] S_POW_STEP = 4'd4;
   localparam logic [3:0] S_ACC_WAIT = 4'd5;
   localparam logic [3:0] S_SQ_WAIT  = 4'd6;
   localparam logic [3:0] S_CHECK    = 4'd7;
   localparam logic [3:0] S_LOOP     = 4'd8;
   localparam logic [3:0] S_X_WAIT   = 4'd9;
   localparam logic [3:0] S_DONE     = 4'd10;

   localparam logic [W-1:0] ONE   = W'(1);
   localparam logic [W-1:0] TWO   = W'(2);
   localparam logic [W-1:0] THREE = W'(3);

   logic [3:0]   state_ff, state_in;
   logic [W-1:0] n_ff, n_in;
   logic [W-1:0] w_ff, w_in;
   logic [W-1:0] d_ff, d_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] iter_ff, iter_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] base_ff, base_in;
   logic         result_ff, result_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_data_ff, rsp_data_in;

   logic         req_take;
   logic         out_load;
   logic [W-1:0] nm1;

   logic         mul_start;
   logic [W-1:0] mul_a;
   logic [W-1:0] mul_b;
   logic         mul_busy;
   logic         mul_done;
   logic [W-1:0] mul_prod;

   mrwt_modmul #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .modulus (n_ff),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign nm1            = n_ff - ONE;
   assign out_load       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      w_in      = w_ff;
      d_in      = d_ff;
      k_in      = k_ff;
      iter_in   = iter_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      result_in = result_ff;
      mul_start = 1'b0;
      mul_a     = acc_ff;
      mul_b     = base_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               n_in     = req_chan.candidate[W-1:0];
               w_in     = req_chan.witness[W-1:0];
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            priority if (n_ff < TWO) begin
               result_in = 1'b0;
               state_in  = S_DONE;
            end else if (n_ff == TWO || n_ff == THREE) begin
               result_in = 1'b1;
               state_in  = S_DONE;
            end else if (!n_ff[0]) begin
               result_in = 1'b0;
               state_in  = S_DONE;
            end else begin
               d_in     = nm1;
               k_in     = '0;
               state_in = S_DECOMP;
            end
         end
         S_DECOMP: begin
            if (!d_ff[0]) begin
               d_in = {1'b0, d_ff[W-1:1]};
               k_in = k_ff + 1'b1;
            end else begin
               // reduce the witness modulo the candidate as 1 * witness
               mul_start = 1'b1;
               mul_a     = ONE;
               mul_b     = w_ff;
               state_in  = S_RED_WAIT;
            end
         end
         S_RED_WAIT: begin
            if (mul_done) begin
               base_in  = mul_prod;
               acc_in   = ONE;
               state_in = S_POW_STEP;
            end
         end
         S_POW_STEP: begin
            priority if (d_ff == '0) begin
               state_in = S_CHECK;
            end else if (d_ff[0]) begin
               mul_start = 1'b1;
               mul_a     = acc_ff;
               mul_b     = base_ff;
               state_in  = S_ACC_WAIT;
            end else begin
               mul_start = 1'b1;
               mul_a     = base_ff;
               mul_b     = base_ff;
               state_in  = S_SQ_WAIT;
            end
         end
         S_ACC_WAIT: begin
            if (mul_done) begin
               acc_in = mul_prod;
               if (d_ff[W-1:1] == '0) begin
                  // last exponent bit, no square needed
                  d_in     = '0;
                  state_in = S_POW_STEP;
               end else begin
                  mul_start = 1'b1;
                  mul_a     = base_ff;
                  mul_b     = base_ff;
                  state_in  = S_SQ_WAIT;
               end
            end
         end
         S_SQ_WAIT: begin
            if (mul_done) begin
               base_in  = mul_prod;
               d_in     = {1'b0, d_ff[W-1:1]};
               state_in = S_POW_STEP;
            end
         end
         S_CHECK: begin
            if (acc_ff == ONE || acc_ff == nm1) begin
               result_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               iter_in  = KW'(1);
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (iter_ff < k_ff) begin
               mul_start = 1'b1;
               mul_a     = acc_ff;
               mul_b     = acc_ff;
               state_in  = S_X_WAIT;
            end else begin
               result_in = 1'b0;
               state_in  = S_DONE;
            end
         end
         S_X_WAIT: begin
            if (mul_done) begin
               acc_in = mul_prod;
               if (mul_prod == nm1) begin
                  result_in = 1'b1;
                  state_in  = S_DONE;
               end else begin
                  iter_in  = iter_ff + 1'b1;
                  state_in = S_LOOP;
               end
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register holds the result until the sink takes it
   always_comb begin
      rsp_data_in = rsp_data_ff;
      priority if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      w_ff        <= w_in;
      d_ff        <= d_in;
      k_ff        <= k_in;
      iter_ff     <= iter_in;
      acc_ff      <= acc_in;
      base_ff     <= base_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.probable_prime = rsp_data_ff;

   `MRWT_ASSERT_SAME(a_start_idle_unit, clock, reset, mul_start, !mul_busy, "multiply started while the unit is busy")
   `MRWT_ASSERT_SAME(a_done_waited, clock, reset, mul_done, state_ff == S_RED_WAIT || state_ff == S_ACC_WAIT || state_ff == S_SQ_WAIT || state_ff == S_X_WAIT, "multiply finished with no state waiting on it")
   `MRWT_ASSERT_NEXT(a_busy_after_take, clock, reset, req_take, !req_chan.ready, "request taken while a transaction is in flight")

endmodule

@@ test/tb_miller_rabin_witness_test_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_miller_rabin_witness_test_core
// Self-checking bench for the single-witness primality test core. A queue
// of candidate/witness pairs feeds a valid/ready driver. Each accepted
// transaction is predicted with exact 64-bit modular arithmetic, and a
// monitor compares every response with the oldest prediction. Directed
// corner cases run first, then random small or even numbers, primes, odd
// numbers, semiprimes and degenerate witnesses. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_miller_rabin_witness_test_core;

   localparam int          NUM_W            = mrwt_pkg::NUM_WIDTH_DEFAULT;
   localparam bit [63:0]   NUM_MASK         = (64'd1 << NUM_W) - 64'd1;
   localparam int          RANDOM_ITEMS     = 150;
   localparam int          TAIL_ITEMS       = 25;
   localparam int          DRAIN_ITEM       = 90;
   localparam int          LONG_HOLD_AT     = 30;
   localparam int          LONG_HOLD_CYCLES = 8000;
   localparam int          SETTLE_CYCLES    = 20;
   localparam int          WATCHDOG_LIMIT   = 40000;
   localparam int          REPORT_LIMIT     = 10;
   localparam bit [31:0]   MR_BASES [12]    = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

   typedef struct {
      bit [31:0] candidate;
      bit [31:0] witness;
      bit        drain_first;
   } test_vector_type;

   typedef struct {
      bit [31:0] candidate;
      bit [31:0] witness;
      bit        probable_prime;
   } verdict_type;

   logic clock;
   logic reset;

   mrwt_req_if req_if ();
   mrwt_rsp_if rsp_if ();

   miller_rabin_witness_test_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   test_vector_type test_vector_q[$];
   verdict_type     verdict_q[$];

   int total_items;
   int sent_count;
   int got_count;
   int fail_count;
   int send_gap;
   int recv_stall;
   int long_hold;
   int idle_cycles;

   always #5 clock = ~clock;

   // exact product reduced modulo m, operands below 2^32
   function automatic bit [63:0] mul_mod(bit [63:0] a, bit [63:0] b, bit [63:0] m);
      return (a * b) % m;
   endfunction

   function automatic bit predict_probable_prime(bit [31:0] cand_in, bit [31:0] wit_in);
      bit [63:0]   n;
      bit [63:0]   nm1;
      bit [63:0]   odd_part;
      bit [63:0]   x;
      bit [63:0]   base;
      bit [63:0]   e;
      int unsigned twos;
      n    = cand_in & NUM_MASK;
      base = wit_in & NUM_MASK;
      if (n < 2) return 1'b0;
      if (n == 2 || n == 3) return 1'b1;
      if (!n[0]) return 1'b0;
      nm1      = n - 1;
      odd_part = nm1;
      twos     = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      x    = 1;
      base = base % n;
      e    = odd_part;
      while (e != 0) begin
         if (e[0]) x = mul_mod(x, base, n);
         base = mul_mod(base, base, n);
         e    = e >> 1;
      end
      if (x == 1 || x == nm1) return 1'b1;
      for (int i = 1; i < twos; i++) begin
         x = mul_mod(x, x, n);
         if (x == nm1) return 1'b1;
      end
      return 1'b0;
   endfunction

   // random prime with the given bit length, checked against fixed bases
   function automatic bit [31:0] random_prime(int unsigned bits);
      bit [31:0] n;
      bit        ok;
      do begin
         n = $urandom();
         if (bits < 32) n = n & ((32'd1 << bits) - 32'd1);
         n[bits-1] = 1'b1;
         n[0]      = 1'b1;
         ok        = (n > 1);
         foreach (MR_BASES[i]) begin
            if (ok && (MR_BASES[i] % n != 0)) ok = predict_probable_prime(n, MR_BASES[i]);
         end
      end while (!ok);
      return n;
   endfunction

   function automatic void add_vector(bit [31:0] cand, bit [31:0] wit, bit drain);
      test_vector_type tv;
      tv.candidate   = cand;
      tv.witness     = wit;
      tv.drain_first = drain;
      test_vector_q.insert(test_vector_q.size(), tv);
   endfunction

   // request driver
   always @(posedge clock) begin
      test_vector_type tv;
      verdict_type     vd;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            vd.candidate      = req_if.candidate;
            vd.witness        = req_if.witness;
            vd.probable_prime = predict_probable_prime(req_if.candidate, req_if.witness);
            verdict_q.insert(verdict_q.size(), vd);
            sent_count++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (test_vector_q.size() != 0 &&
                         !(test_vector_q[0].drain_first && verdict_q.size() != 0)) begin
               tv = test_vector_q.pop_front();
               req_if.valid     <= 1'b1;
               req_if.candidate <= tv.candidate;
               req_if.witness   <= tv.witness;
               if (sent_count < total_items - TAIL_ITEMS && $urandom_range(7, 0) == 0)
                  send_gap = $urandom_range(14, 1);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready control
   always @(posedge clock) begin
      verdict_type vd;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_stall = 0;
         long_hold  = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got_count++;
            if (verdict_q.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: response with no transaction pending, got %0b",
                           $realtime, rsp_if.probable_prime);
            end else begin
               vd = verdict_q.pop_front();
               if (rsp_if.probable_prime !== vd.probable_prime) begin
                  fail_count++;
                  if (fail_count <= REPORT_LIMIT)
                     $display("%0t: mismatch candidate %0d witness %0d expected %0b got %0b",
                              $realtime, vd.candidate, vd.witness, vd.probable_prime,
                              rsp_if.probable_prime);
               end
            end
            // hold off long enough for the core to back up its request side
            if (got_count == LONG_HOLD_AT) long_hold = LONG_HOLD_CYCLES;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_if.ready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (got_count < total_items - TAIL_ITEMS && $urandom_range(5, 0) == 0)
               recv_stall = $urandom_range(14, 1);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, idle_cycles);
            $display("FAIL miller_rabin_witness_test_core");
            $finish;
         end
      end
   end

   initial begin
      bit [31:0] cand;
      bit [31:0] wit;
      bit [31:0] p;
      bit [31:0] q;
      int        sel;

      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.candidate = '0;
      req_if.witness   = '0;
      rsp_if.ready     = 1'b0;
      sent_count       = 0;
      got_count        = 0;
      fail_count       = 0;
      idle_cycles      = 0;

      // trivial candidates, the even shortcut and two odd composites
      add_vector(32'd0, 32'd5, 1'b0);
      add_vector(32'd1, 32'hFFFF_FFFF, 1'b0);
      add_vector(32'd2, 32'd0, 1'b0);
      add_vector(32'd3, 32'd7, 1'b0);
      add_vector(32'd4, 32'd3, 1'b0);
      add_vector(32'hFFFF_FFFE, 32'd3, 1'b0);
      add_vector(32'd9, 32'd2, 1'b0);
      add_vector(32'hFFFF_FFFF, 32'd2, 1'b0);
      // largest 32-bit prime with ordinary and degenerate witnesses
      add_vector(32'd4294967291, 32'd2, 1'b0);
      add_vector(32'd4294967291, 32'd0, 1'b0);
      add_vector(32'd4294967291, 32'd4294967291, 1'b0);
      add_vector(32'd4294967291, 32'd1, 1'b0);
      add_vector(32'd4294967291, 32'd4294967290, 1'b0);
      add_vector(32'd4294967291, 32'hFFFF_FFFF, 1'b0);
      // strong pseudoprimes and carmichael numbers
      add_vector(32'd2047, 32'd2, 1'b0);
      add_vector(32'd3215031751, 32'd2, 1'b0);
      add_vector(32'd561, 32'd2, 1'b0);
      add_vector(32'd25, 32'd7, 1'b0);
      // long run of squarings, witness above the candidate
      add_vector(32'd65537, 32'd3, 1'b0);
      add_vector(32'd13, 32'd14, 1'b0);
      add_vector(32'd13, 32'd25, 1'b0);
      add_vector(32'd5, 32'h7FFF_FFFF, 1'b0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         sel = $urandom_range(99, 0);
         if (sel < 10) begin
            cand = $urandom();
            if ($urandom_range(1, 0)) cand = $urandom_range(3, 0);
            else cand[0] = 1'b0;
            wit = $urandom();
         end else if (sel < 45) begin
            cand = random_prime(($urandom_range(3, 0) == 0) ? $urandom_range(31, 2) : 32);
            wit  = ($urandom_range(3, 0) == 0) ? $urandom() : $urandom_range(cand - 2, 2);
         end else if (sel < 80) begin
            cand = $urandom() | 32'd1;
            wit  = $urandom();
         end else if (sel < 90) begin
            p    = random_prime($urandom_range(16, 2));
            q    = random_prime($urandom_range(16, 2));
            cand = p * q;
            wit  = $urandom_range(cand - 2, 2);
         end else begin
            // witness congruent to zero, one or minus one
            cand = ($urandom_range(1, 0)) ? random_prime(32) : ($urandom() | 32'd1);
            case ($urandom_range(4, 0))
               0:       wit = cand;
               1:       wit = 32'd0;
               2:       wit = cand + 32'd1;
               3:       wit = 32'd1;
               default: wit = cand - 32'd1;
            endcase
         end
         add_vector(cand, wit, i == DRAIN_ITEM);
      end
      total_items = test_vector_q.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (sent_count < total_items || verdict_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (fail_count == 0 && verdict_q.size() == 0)
         $display("PASS miller_rabin_witness_test_core");
      else
         $display("FAIL miller_rabin_witness_test_core");
      $finish;
   end

endmodule
